// ===== sv/frct_pkg.sv =====
// shared types, constants and match function for the function range call tracer
package frct_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int STACK_DEPTH = 128;

  localparam int ADDR_W    = 32;
  localparam int IDX_W     = $clog2(TABLE_DEPTH);
  localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_IDX_W = 12;
  localparam int DEPTH_W   = 8;
  localparam int STATUS_W  = 3;
  localparam int OP_W      = 2;

  localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
  localparam logic [OP_W-1:0] OP_CALL     = 2'd1;
  localparam logic [OP_W-1:0] OP_RETURN   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STACK_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STACK_EMPTY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_START   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              entry_is_function;
    logic [ADDR_W-1:0] entry_start;
    logic [ADDR_W-1:0] entry_end;
    logic [ADDR_W-1:0] event_pc;
    logic [ADDR_W-1:0] event_target;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 source_found;
    logic [OUT_IDX_W-1:0] source_index;
    logic                 dest_found;
    logic [OUT_IDX_W-1:0] dest_index;
    logic [DEPTH_W-1:0]   nest_level;
  } result_t;

  typedef struct packed {
    logic              is_range;
    logic [ADDR_W-1:0] range_start;
    logic [ADDR_W-1:0] range_end;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  // range entries match [start,end), exact entries match start only
  function automatic logic entry_hit(entry_t e, logic [ADDR_W-1:0] a);
    logic hit;
    if (e.is_range) begin
      hit = (a >= e.range_start) && (a < e.range_end);
    end else begin
      hit = (a == e.range_start);
    end
    return hit;
  endfunction

endpackage

// ===== sv/frct_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module frct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/function_range_call_tracer.sv =====
// top level of the function range call tracer: symbol table scan and call-depth tracking
//
// Takes one transaction at a time on the input channel and returns exactly one result
// transaction for each. A register transaction appends an entry to the symbol table,
// held in one ram of TABLE_DEPTH entries (kind, start, end), if it has room. A call or
// return transaction walks the table from entry 0 through the single ram read port,
// one entry per clock, comparing each entry against both the pc and the target at
// once, and stops as soon as both have matched or the registered entries run out.
// Table contents are undefined after reset and need no clearing: only entries below
// the entry count are ever read. The result sits in an output register, so a stalled
// result does not block acceptance of the next transaction; the result of that one
// then waits until the output register frees up.
module function_range_call_tracer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  frct_pkg::item_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output frct_pkg::result_t out_data_o
);
  import frct_pkg::*;

  state_e             state_q, state_d;
  item_t              item_q, item_d;
  logic               full_q, full_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;

  // scan pointer and read pipeline
  logic [CNT_W-1:0]   issue_q, issue_d;
  logic [CNT_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic               data_vld_q, data_vld_d;

  // lookup results
  logic               sfound_q, sfound_d;
  logic [IDX_W-1:0]   sidx_q, sidx_d;
  logic               dfound_q, dfound_d;
  logic [IDX_W-1:0]   didx_q, didx_d;
  logic               dnot_start_q, dnot_start_d;

  logic               out_valid_q, out_valid_d;
  result_t            out_q, out_d;

  logic               in_accept;
  logic               out_free;
  logic               both_found;
  logic               ram_we;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             wr_entry;
  entry_t             rd_entry;
  logic               s_hit;
  logic               d_hit;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign both_found = sfound_q && dfound_q;

  // new entries go straight into the table in the accept cycle
  assign wr_entry.is_range    = in_data_i.entry_is_function;
  assign wr_entry.range_start = in_data_i.entry_start;
  assign wr_entry.range_end   = in_data_i.entry_end;
  assign ram_we = in_accept && (in_data_i.op == OP_REGISTER) &&
                  (count_q < CNT_W'(TABLE_DEPTH));

  // one read per cycle while entries remain and a lookup is still open
  assign ram_re = (state_q == S_SCAN) && (issue_q < count_q) && !both_found;

  frct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (issue_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);
  assign s_hit    = entry_hit(rd_entry, item_q.event_pc);
  assign d_hit    = entry_hit(rd_entry, item_q.event_target);

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    full_d       = full_q;
    count_d      = count_q;
    depth_d      = depth_q;
    issue_d      = issue_q;
    cmp_idx_d    = cmp_idx_q;
    data_vld_d   = ram_re;
    sfound_d     = sfound_q;
    sidx_d       = sidx_q;
    dfound_d     = dfound_q;
    didx_d       = didx_q;
    dnot_start_d = dnot_start_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;

    if (ram_re) begin
      issue_d   = issue_q + CNT_W'(1);
      cmp_idx_d = issue_q;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          item_d   = in_data_i;
          sfound_d = 1'b0;
          sidx_d   = '0;
          dfound_d = 1'b0;
          didx_d   = '0;
          dnot_start_d = 1'b0;
          issue_d  = '0;
          full_d   = !(count_q < CNT_W'(TABLE_DEPTH));
          if (ram_we) begin
            count_d = count_q + CNT_W'(1);
          end
          if (in_data_i.op inside {OP_CALL, OP_RETURN}) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_FINISH;
          end
        end
      end

      S_SCAN: begin
        // keep only the first match of each lookup
        if (data_vld_q) begin
          if (!sfound_q && s_hit) begin
            sfound_d = 1'b1;
            sidx_d   = cmp_idx_q[IDX_W-1:0];
          end
          if (!dfound_q && d_hit) begin
            dfound_d     = 1'b1;
            didx_d       = cmp_idx_q[IDX_W-1:0];
            dnot_start_d = (item_q.event_target != rd_entry.range_start);
          end
        end
        if (both_found || (!data_vld_q && (issue_q == count_q))) begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.status       = ST_OK;
          out_d.source_found = 1'b0;
          out_d.source_index = '0;
          out_d.dest_found   = 1'b0;
          out_d.dest_index   = '0;
          out_d.nest_level   = depth_q;
          case (item_q.op)
            OP_REGISTER: begin
              if (full_q) begin
                out_d.status = ST_TABLE_FULL;
              end
            end
            OP_CALL, OP_RETURN: begin
              out_d.source_found = sfound_q;
              out_d.source_index = OUT_IDX_W'(sidx_q);
              out_d.dest_found   = dfound_q;
              out_d.dest_index   = OUT_IDX_W'(didx_q);
              if (item_q.op == OP_CALL) begin
                // not-at-start check has priority over the stack check
                if (dfound_q && dnot_start_q) begin
                  out_d.status = ST_NOT_START;
                end else if (depth_q >= DEPTH_W'(STACK_DEPTH)) begin
                  out_d.status = ST_STACK_FULL;
                end else begin
                  depth_d = depth_q + DEPTH_W'(1);
                end
              end else begin
                if (depth_q == '0) begin
                  out_d.status     = ST_STACK_EMPTY;
                  out_d.nest_level = '0;
                end else begin
                  depth_d          = depth_q - DEPTH_W'(1);
                  out_d.nest_level = depth_q - DEPTH_W'(1);
                end
              end
            end
            default: begin
              // unused op: plain ok result with the current depth
            end
          endcase
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      depth_q     <= '0;
      issue_q     <= '0;
      data_vld_q  <= 1'b0;
      sfound_q    <= 1'b0;
      dfound_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      depth_q     <= depth_d;
      issue_q     <= issue_d;
      data_vld_q  <= data_vld_d;
      sfound_q    <= sfound_d;
      dfound_q    <= dfound_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    full_q       <= full_d;
    cmp_idx_q    <= cmp_idx_d;
    sidx_q       <= sidx_d;
    didx_q       <= didx_d;
    dnot_start_q <= dnot_start_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // table never holds more entries than it has room for
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // call depth stays within the stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(STACK_DEPTH))
    else $error("call depth beyond stack depth");

  // the scan only compares registered entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && data_vld_q |-> cmp_idx_q < count_q)
    else $error("scan compared an unregistered entry");

  // depth only moves when a result is loaded into the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(depth_q) |-> $past(state_q == S_FINISH) && out_valid_q)
    else $error("call depth changed without a result");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the function range call tracer: directed and random runs
`timescale 1ns / 100ps

module testbench;
  import frct_pkg::*;

  // op code 3 has no meaning for the block, it just answers with the current depth
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // the quiet limit leaves room for a full-table scan plus stalls on the output side
  localparam int QUIET_LIMIT = 50000;
  localparam int LONG_HOLD   = 300;

  logic    clk      = 1'b0;
  logic    rst_n    = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  item_t   in_data  = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  result_t out_data;

  // shadow of the symbol table and the call-depth counter
  logic [ADDR_W-1:0] sym_start [TABLE_DEPTH];
  logic [ADDR_W-1:0] sym_end   [TABLE_DEPTH];
  logic              sym_kind  [TABLE_DEPTH];
  int unsigned       sym_count  = 0;
  int unsigned       call_depth = 0;

  item_t       trace_items[$];    // transactions waiting to be offered
  result_t     trace_reports[$];  // reports owed by the block, oldest first
  logic [31:0] fn_lo[$];          // function ranges registered so far, for well-formed jumps
  logic [31:0] fn_hi[$];

  int unsigned queued_count = 0;
  int unsigned taken_count  = 0;
  int          send_idle_pct = 13;
  int          recv_idle_pct = 53;
  bit          hold_req  = 1'b0;
  int          hold_left = 0;
  bit          in_taken  = 1'b0;
  int          errors    = 0;
  int          quiet_cycles = 0;

  function_range_call_tracer DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #5 clk = ~clk;

  // first entry in table order that covers addr
  function automatic void find_symbol(input logic [ADDR_W-1:0] addr, output logic hit,
                                      output int unsigned idx);
    hit = 1'b0;
    idx = 0;
    for (int unsigned i = 0; i < sym_count && !hit; i++) begin
      if (sym_kind[i] ? (addr >= sym_start[i] && addr < sym_end[i])
                      : (addr == sym_start[i])) begin
        hit = 1'b1;
        idx = i;
      end
    end
  endfunction

  // updates the shadow state for one transaction and returns the report it owes
  function automatic result_t step_tracer(item_t it);
    result_t     rep;
    logic        src_hit, dst_hit;
    int unsigned src_idx, dst_idx;
    rep = '0;
    rep.nest_level = DEPTH_W'(call_depth);
    if (it.op == OP_REGISTER) begin
      if (sym_count >= TABLE_DEPTH) begin
        rep.status = ST_TABLE_FULL;
      end else begin
        sym_kind[sym_count]  = it.entry_is_function;
        sym_start[sym_count] = it.entry_start;
        sym_end[sym_count]   = it.entry_end;
        sym_count++;
      end
    end else if (it.op == OP_CALL || it.op == OP_RETURN) begin
      find_symbol(it.event_pc, src_hit, src_idx);
      find_symbol(it.event_target, dst_hit, dst_idx);
      rep.source_found = src_hit;
      rep.source_index = OUT_IDX_W'(src_idx);
      rep.dest_found   = dst_hit;
      rep.dest_index   = OUT_IDX_W'(dst_idx);
      if (it.op == OP_CALL) begin
        // landing inside a function but off its start wins over the depth check
        if (dst_hit && it.event_target != sym_start[dst_idx]) begin
          rep.status = ST_NOT_START;
        end else if (call_depth >= STACK_DEPTH) begin
          rep.status = ST_STACK_FULL;
        end else begin
          call_depth++;
        end
      end else if (call_depth == 0) begin
        rep.status     = ST_STACK_EMPTY;
        rep.nest_level = '0;
      end else begin
        call_depth--;
        rep.nest_level = DEPTH_W'(call_depth);
      end
    end
    return rep;
  endfunction

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  function automatic void queue_item(item_t it);
    trace_items.push_back(it);
    queued_count++;
  endfunction

  // fields that the op does not use get random noise
  function automatic void add_symbol(logic kind, logic [31:0] lo, logic [31:0] hi);
    queue_item('{OP_REGISTER, kind, lo, hi, $urandom, $urandom});
  endfunction

  function automatic void add_jump(logic [OP_W-1:0] op, logic [31:0] pc, logic [31:0] tgt);
    queue_item('{op, 1'($urandom), $urandom, $urandom, pc, tgt});
  endfunction

  // start of a known function, now and then an arbitrary address
  function automatic logic [31:0] pick_start();
    if (fn_lo.size() == 0 || $urandom_range(4) == 0) return $urandom;
    return fn_lo[$urandom_range(fn_lo.size() - 1)];
  endfunction

  // address inside a known function, now and then an arbitrary one
  function automatic logic [31:0] pick_inside();
    int unsigned k;
    if (fn_lo.size() == 0 || $urandom_range(4) == 0) return $urandom;
    k = $urandom_range(fn_lo.size() - 1);
    return fn_lo[k] + $urandom_range(fn_hi[k] - fn_lo[k] - 1);
  endfunction

  // mostly well-formed symbol / call / return traffic; returns 0 for an unused op
  function automatic bit add_random_item();
    int unsigned pick, len, k;
    logic [31:0] lo, tgt;
    pick = $urandom_range(99);
    if (pick < 12) begin
      lo  = $urandom;
      len = $urandom_range(1, 4096);
      if (pick < 2) begin
        add_symbol(1'b1, lo, $urandom);          // arbitrary end, often an empty range
      end else if (pick < 5) begin
        add_symbol(1'b0, lo, $urandom);          // exact-address entry
      end else begin
        add_symbol(1'b1, lo, lo + len);
        if (lo + len > lo) begin
          fn_lo.push_back(lo);
          fn_hi.push_back(lo + len);
        end
      end
    end else if (pick < 50) begin
      k   = $urandom_range(9);
      tgt = (k < 7) ? pick_start() : (k < 9) ? pick_inside() : $urandom;
      add_jump(OP_CALL, pick_inside(), tgt);
    end else if (pick < 85) begin
      add_jump(OP_RETURN, pick_inside(), pick_inside());
    end else if (pick < 92) begin
      queue_item('{OP_UNUSED, 1'($urandom), $urandom, $urandom, $urandom, $urandom});
      return 1'b0;
    end else begin
      queue_item('{OP_W'($urandom_range(2)), 1'($urandom), $urandom, $urandom, $urandom,
                   $urandom});
    end
    return 1'b1;
  endfunction

  task automatic run_random(int unsigned n);
    int unsigned counted;
    counted = 0;
    while (counted < n) begin
      if (add_random_item()) counted++;
    end
  endtask

  // wait until every queued transaction was taken and every report came back
  task automatic drain();
    do @(negedge clk);
    while (taken_count != queued_count || trace_reports.size() != 0);
  endtask

  // driver: a new transaction only once the previous one was taken, held while stalled
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (trace_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= trace_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off counted here so the block backs up
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_req  <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor: check the report first, then predict the transaction taken at this edge
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (trace_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none, actual %p", $time, out_data);
          errors++;
        end else begin
          want = trace_reports.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("source_found", 32'(want.source_found), 32'(out_data.source_found));
          check_field("source_index", 32'(want.source_index), 32'(out_data.source_index));
          check_field("dest_found", 32'(want.dest_found), 32'(out_data.dest_found));
          check_field("dest_index", 32'(want.dest_index), 32'(out_data.dest_index));
          check_field("nest_level", 32'(want.nest_level), 32'(out_data.nest_level));
        end
      end
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        trace_reports.push_back(step_tracer(in_data));
        taken_count++;
      end
    end
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table and empty stack first
    add_jump(OP_RETURN, 32'h0, 32'h0);
    add_jump(OP_CALL, 32'h100, 32'h200);
    queue_item('{OP_UNUSED, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0});
    // entries: extremes, an empty and an inverted range, overlapping functions
    add_symbol(1'b0, 32'h0, 32'hFFFF_FFFF);
    add_symbol(1'b1, 32'h1000, 32'h2000);
    add_symbol(1'b1, 32'hFFFF_FF00, 32'hFFFF_FFFF);
    add_symbol(1'b1, 32'h5000, 32'h5000);
    add_symbol(1'b1, 32'h6000, 32'h5F00);
    add_symbol(1'b0, 32'hFFFF_FFFF, 32'h0);
    add_symbol(1'b1, 32'h1800, 32'h3000);
    add_jump(OP_CALL, 32'h0, 32'h1000);
    add_jump(OP_CALL, 32'h1900, 32'h1004);            // lands off the function start
    add_jump(OP_CALL, 32'h2500, 32'h5000);            // empty range matches nothing
    add_jump(OP_CALL, 32'hFFFF_FF80, 32'hFFFF_FFFF);
    add_jump(OP_CALL, 32'h6000, 32'h1800);            // earlier overlapping entry wins
    add_jump(OP_RETURN, 32'h1FFF, 32'h2000);
    repeat (3) add_jump(OP_RETURN, 32'h1004, 32'h0);
    add_jump(OP_RETURN, 32'h0, 32'h1000);             // pop below zero
    queue_item('{OP_UNUSED, 1'b1, '1, '1, '1, '1});
    add_jump(OP_CALL, 32'hFFFF_FFFF, 32'h0);
    drain();

    run_random(40);
    drain();
    send_idle_pct = 53;
    recv_idle_pct = 13;
    run_random(40);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(30);
    hold_req = 1'b1;
    drain();

    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/frct_pkg.sv
sv/frct_ram.sv
sv/function_range_call_tracer.sv
tb/testbench.sv
